// ===== hw/rtl/shs_pkg.sv =====
// Shared types and constants for the segment height sampler.
// Holds the request and response structs and the records passed between stages.
// Has no dependencies; the design files refer to it by scoped names and the testbench imports it.
package shs_pkg;

  // Number of register stages from request to response.
  localparam int STAGES    = 9;
  // Binary point of the curve parameter t and of every de Casteljau step.
  localparam int FRAC      = 10;
  // Shift that turns the relative position times scale into t.
  localparam int T_SHIFT   = 16;
  // End coordinates and heights are scaled by 32.
  localparam int HSCALE    = 5;
  // Binary point of the straight-mode rise.
  localparam int RISE_FRAC = 8;

  typedef struct packed {
    logic               curved;
    logic               along_x;
    logic signed [15:0] first_coord;
    logic signed [15:0] second_coord;
    logic signed [15:0] first_height;
    logic signed [15:0] second_height;
    logic signed [31:0] probe_pos;
    logic signed [15:0] rise;
    logic signed [7:0]  slope_start;
    logic signed [7:0]  slope_end;
    logic        [15:0] param_scale;
    logic signed [15:0] start_handle;
  } req_t;

  typedef struct packed {
    logic signed [31:0] height;
    logic               on_segment;
    logic signed [7:0]  slope_on_x;
    logic signed [7:0]  slope_on_y;
    logic signed [7:0]  slope_value;
    logic               axis_is_x;
    logic signed [31:0] offset_from_first;
  } rsp_t;

  // Control points and slope terms of the curve, fixed per item.
  typedef struct packed {
    logic signed [20:0] h0;
    logic signed [20:0] d1;
    logic signed [21:0] nd2;
    logic signed [21:0] p1;
    logic signed [21:0] p2;
    logic signed [22:0] dp;
    logic signed [7:0]  s0;
    logic signed [8:0]  ds;
  } coef_t;

  // Fields that ride alongside the arithmetic until the response is built.
  typedef struct packed {
    logic               curved;
    logic               along_x;
    logic               desc;
    logic               on_seg;
    logic               in_span;
    logic        [31:0] offset;
    logic        [31:0] hclamp;
  } carry_t;

  // Output of the set-up stage.
  typedef struct packed {
    coef_t              coef;
    logic        [31:0] rel0;
    logic        [31:0] pos;
    logic        [21:0] range;
    logic signed [20:0] zlo;
    logic signed [20:0] zhi;
    logic signed [15:0] rise;
    logic        [15:0] scale;
    carry_t             carry;
  } front_t;

  // Output of the parameter stages: t, clamped height and span flags.
  typedef struct packed {
    coef_t              coef;
    logic        [31:0] t;
    carry_t             carry;
  } param_t;

endpackage

// ===== hw/rtl/segment_height_sampler.sv =====
// Top level of the segment height sampler: stage valid chain and flow control.
// Depends on shs_pkg, shs_front, shs_param and shs_bezier.
//
// Usage. Each transfer on the req channel carries one terrain segment and
// one probe position; each transfer on the rsp channel carries the sampled
// height, the on-segment flag, the slope on the segment's axis and the
// straight-mode offset from the first point. Every request gives exactly one
// response, in order. The block keeps no state between items.
//
// Pipeline. Each request passes through one set-up stage, two stages that
// form the curve parameter t and the straight height, and six stages of de
// Casteljau multiply and add, the last of which is the response register.
// The depth is set by the three dependent multiplications of the curve
// evaluation. One request is taken in every cycle while the receiver does
// not stall, so up to nine items are in flight.
//
// Stalls. Each stage has its own valid bit and moves forward whenever the
// stage after it is empty or moving, so a stalled receiver halts only the
// full stages behind it; empty stages keep filling. req_ready falls only
// when every stage holds an item. Nothing is dropped or repeated.
//
// Reset. rst is synchronous and active high; it clears all stage valid bits,
// so rsp_valid is low in the cycle after reset and no stale item appears.
module segment_height_sampler (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  shs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output shs_pkg::rsp_t rsp
);

  localparam int N = shs_pkg::STAGES;

  // vld[i] marks that stage i holds an item; rdy[i] lets stage i load.
  logic [N:1] vld;
  logic [N:1] rdy;

  shs_pkg::front_t front;
  shs_pkg::param_t param;

  always_comb begin
    rdy[N] = !vld[N] || rsp_ready;
    for (int i = N - 1; i >= 1; i--) begin
      rdy[i] = !vld[i] || rdy[i + 1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= req_valid;
      end
      for (int i = 2; i <= N; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i - 1];
        end
      end
    end
  end

  assign req_ready = rdy[1];
  assign rsp_valid = vld[N];

  shs_front u_front (
    .clk   (clk),
    .en    (rdy[1]),
    .req   (req),
    .front (front)
  );

  shs_param u_param (
    .clk   (clk),
    .en    (rdy[3:2]),
    .front (front),
    .param (param)
  );

  shs_bezier u_bezier (
    .clk   (clk),
    .en    (rdy[N:4]),
    .param (param),
    .rsp   (rsp)
  );

  // An accepted request always lands in the first stage.
  a_req_lands: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> vld[1])
    else $error("accepted request did not enter the first stage");

  // Back-pressure reaches the request side only when the pipeline is full.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> (&vld))
    else $error("request side blocked with an empty stage");

  // A middle stage that cannot move keeps its item.
  a_mid_holds: assert property (@(posedge clk) disable iff (rst)
    vld[5] && !rdy[6] |=> vld[5])
    else $error("stalled item lost in the middle of the pipeline");

  // The slope appears on exactly the component named by the axis flag.
  a_slope_axis: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.axis_is_x ?
      (rsp.slope_on_x == rsp.slope_value && rsp.slope_on_y == 8'sd0) :
      (rsp.slope_on_y == rsp.slope_value && rsp.slope_on_x == 8'sd0)))
    else $error("slope placed on the wrong component");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid straight after reset");

endmodule

// ===== hw/rtl/shs_front.sv =====
// Set-up stage of the segment height sampler: scaling, end ordering and span.
// Depends on shs_pkg for the request struct and the front_t stage record.
module shs_front (
  input  logic            clk,
  input  logic            en,
  input  shs_pkg::req_t   req,
  output shs_pkg::front_t front
);

  logic signed [20:0] c0, c1, h0, h1, d1, d2, lo, hi;
  logic               asc;
  logic        [31:0] rel0;
  shs_pkg::front_t    front_next;

  always_comb begin
    c0  = {req.first_coord,   {shs_pkg::HSCALE{1'b0}}};
    c1  = {req.second_coord,  {shs_pkg::HSCALE{1'b0}}};
    h0  = {req.first_height,  {shs_pkg::HSCALE{1'b0}}};
    h1  = {req.second_height, {shs_pkg::HSCALE{1'b0}}};
    d1  = {req.start_handle,  {shs_pkg::HSCALE{1'b0}}};
    d2  = {req.rise,          {shs_pkg::HSCALE{1'b0}}};
    asc = c0 < c1;
    lo  = asc ? c0 : c1;
    hi  = asc ? c1 : c0;
    rel0 = 32'(req.probe_pos) - 32'(c0);

    front_next.coef.h0  = h0;
    front_next.coef.d1  = d1;
    front_next.coef.nd2 = 22'sd0 - 22'(d2);
    front_next.coef.p1  = 22'(h0) + 22'(d1);
    front_next.coef.p2  = 22'(h1) + 22'(d2);
    front_next.coef.dp  = 23'(front_next.coef.p2) - 23'(front_next.coef.p1);
    front_next.coef.s0  = req.slope_start;
    front_next.coef.ds  = 9'(req.slope_end) - 9'(req.slope_start);

    front_next.rel0  = rel0;
    front_next.pos   = 32'(req.probe_pos) - 32'(lo);
    front_next.range = 22'(22'(hi) - 22'(lo));
    front_next.zlo   = asc ? h0 : h1;
    front_next.zhi   = asc ? h1 : h0;
    front_next.rise  = req.rise;
    front_next.scale = req.param_scale;

    front_next.carry.curved  = req.curved;
    front_next.carry.along_x = req.along_x;
    front_next.carry.desc    = c1 < c0;
    front_next.carry.on_seg  = 1'b0;
    front_next.carry.in_span = 1'b0;
    front_next.carry.offset  = req.curved ? 32'd0 : rel0;
    front_next.carry.hclamp  = 32'd0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front <= front_next;
    end
  end

endmodule

// ===== hw/rtl/shs_param.sv =====
// Parameter stages of the segment height sampler: t, straight height and clamping.
// Depends on shs_pkg for the front_t and param_t stage records.
module shs_param (
  input  logic            clk,
  input  logic [1:0]      en,
  input  shs_pkg::front_t front,
  output shs_pkg::param_t param
);

  // Second stage: the two products and the span compares.
  shs_pkg::coef_t     coef2;
  shs_pkg::carry_t    carry2;
  logic        [31:0] tr2, sp2;
  logic signed [20:0] zlo2, zhi2;
  logic               below2, beyond2, on_s2;

  logic        [31:0] tp;
  logic               inside3;
  logic        [31:0] straight_h;
  shs_pkg::param_t    param_next;

  // The product wraps at 32 bits before the arithmetic shift forms t.
  assign tp = front.rel0 * 32'(front.scale);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      coef2   <= front.coef;
      carry2  <= front.carry;
      tr2     <= 32'($signed(tp) >>> shs_pkg::T_SHIFT);
      sp2     <= 32'(front.rise) * front.pos;
      zlo2    <= front.zlo;
      zhi2    <= front.zhi;
      below2  <= front.pos[31];
      beyond2 <= $signed(front.pos) >= $signed({10'd0, front.range});
      on_s2   <= !front.pos[31] && !($signed({10'd0, front.range}) < $signed(front.pos));
    end
  end

  always_comb begin
    inside3    = !below2 && !beyond2;
    straight_h = 32'(zlo2) + 32'($signed(sp2) >>> shs_pkg::RISE_FRAC);
    param_next.coef  = coef2;
    param_next.t     = carry2.desc ? 32'd0 - tr2 : tr2;
    param_next.carry = carry2;
    param_next.carry.in_span = inside3;
    param_next.carry.on_seg = carry2.curved ? inside3 : on_s2;
    if (below2) begin
      param_next.carry.hclamp = 32'(zlo2);
    end else if (beyond2) begin
      param_next.carry.hclamp = 32'(zhi2);
    end else begin
      param_next.carry.hclamp = straight_h;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      param <= param_next;
    end
  end

endmodule

// ===== hw/rtl/shs_bezier.sv =====
// De Casteljau stages of the segment height sampler and the response register.
// Depends on shs_pkg for param_t, carry_t and the response struct.
module shs_bezier (
  input  logic            clk,
  input  logic [5:0]      en,
  input  shs_pkg::param_t param,
  output shs_pkg::rsp_t   rsp
);

  localparam int MSW = shs_pkg::FRAC + 8;

  // Stage 4: first-level products.
  logic        [31:0] m0, m1, m2, t4;
  logic        [MSW-1:0] ms;
  logic signed [20:0] h04;
  logic signed [21:0] p14, p24;
  logic signed [7:0]  s04;
  shs_pkg::carry_t    carry4;

  // Stage 5: first-level points and their differences.
  logic        [31:0] q0, q1, e0, e1, t5;
  logic        [31:0] q0_next, q1_next, q2_next;
  logic        [7:0]  sum8, slope5;
  shs_pkg::carry_t    carry5;

  // Stage 6: second-level products.
  logic        [31:0] n0, n1, q06, q16, t6;
  logic        [7:0]  slope6;
  shs_pkg::carry_t    carry6;

  // Stage 7: second-level points.
  logic        [31:0] r0, f, t7, r0_next, r1_next;
  logic        [7:0]  slope7;
  shs_pkg::carry_t    carry7;

  // Stage 8: last product.
  logic        [31:0] nf, r08;
  logic        [7:0]  slope8;
  shs_pkg::carry_t    carry8;

  logic        [31:0] curve_h;
  shs_pkg::rsp_t      rsp_next;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m0     <= 32'(param.coef.d1)  * param.t;
      m1     <= 32'(param.coef.dp)  * param.t;
      m2     <= 32'(param.coef.nd2) * param.t;
      ms     <= MSW'(param.coef.ds) * param.t[MSW-1:0];
      t4     <= param.t;
      h04    <= param.coef.h0;
      p14    <= param.coef.p1;
      p24    <= param.coef.p2;
      s04    <= param.coef.s0;
      carry4 <= param.carry;
    end
  end

  always_comb begin
    q0_next = 32'(h04) + 32'($signed(m0) >>> shs_pkg::FRAC);
    q1_next = 32'(p14) + 32'($signed(m1) >>> shs_pkg::FRAC);
    q2_next = 32'(p24) + 32'($signed(m2) >>> shs_pkg::FRAC);
    sum8    = s04 + ms[MSW-1:shs_pkg::FRAC];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      q0     <= q0_next;
      q1     <= q1_next;
      e0     <= q1_next - q0_next;
      e1     <= q2_next - q1_next;
      t5     <= t4;
      // A straight segment reports its start slope unchanged.
      slope5 <= !carry4.curved ? s04 : (carry4.desc ? 8'd0 - sum8 : sum8);
      carry5 <= carry4;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      n0     <= e0 * t5;
      n1     <= e1 * t5;
      q06    <= q0;
      q16    <= q1;
      t6     <= t5;
      slope6 <= slope5;
      carry6 <= carry5;
    end
  end

  always_comb begin
    r0_next = q06 + 32'($signed(n0) >>> shs_pkg::FRAC);
    r1_next = q16 + 32'($signed(n1) >>> shs_pkg::FRAC);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      r0     <= r0_next;
      f      <= r1_next - r0_next;
      t7     <= t6;
      slope7 <= slope6;
      carry7 <= carry6;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      nf     <= f * t7;
      r08    <= r0;
      slope8 <= slope7;
      carry8 <= carry7;
    end
  end

  always_comb begin
    curve_h = r08 + 32'($signed(nf) >>> shs_pkg::FRAC);
    rsp_next.height            = (carry8.curved && carry8.in_span) ? curve_h : carry8.hclamp;
    rsp_next.on_segment        = carry8.on_seg;
    rsp_next.slope_on_x        = carry8.along_x ? slope8 : 8'd0;
    rsp_next.slope_on_y        = carry8.along_x ? 8'd0 : slope8;
    rsp_next.slope_value       = slope8;
    rsp_next.axis_is_x         = carry8.along_x;
    rsp_next.offset_from_first = carry8.offset;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== sim/segment_height_sampler_tb.sv =====
// Self-checking testbench for segment_height_sampler: directed and random segment/probe transfers.
// Depends on shs_pkg for the request and response structs and the stage count.
// An in-bench scoreboard predicts every response and compares it field by field, in order.
module segment_height_sampler_tb;
  import shs_pkg::*;

  // Keeps the predicted responses of accepted requests, oldest first, and
  // compares each response transfer against the oldest one.
  class height_scoreboard;
    rsp_t expected_samples[$];
    int   errors = 0;
    int   requests = 0;
    int   curved_requests = 0;
    int   responses = 0;
    int   on_segment_hits = 0;

    // One de Casteljau step in 10-bit fixed point; int arithmetic wraps at 32 bits.
    function int lerp10(int a, int b, int t);
      return a + (((b - a) * t) >>> FRAC);
    endfunction

    function rsp_t predict_sample(req_t r);
      int   c0, c1, h0, h1, probe, rise, s0, s1, scale, hand;
      int   height, slope, offset, lo, hi, zlo, zhi, span, rel, pos, t;
      int   d1, d2, q0, q1, q2, m0, m1;
      bit   on, desc;
      rsp_t o;
      c0 = int'(r.first_coord) <<< HSCALE;
      c1 = int'(r.second_coord) <<< HSCALE;
      h0 = int'(r.first_height) <<< HSCALE;
      h1 = int'(r.second_height) <<< HSCALE;
      probe = r.probe_pos;
      rise = r.rise;
      s0 = r.slope_start;
      s1 = r.slope_end;
      scale = r.param_scale;
      hand = r.start_handle;
      offset = 0;
      if (!r.curved) begin
        offset = probe - c0;
        slope = s0;
        // With equal coordinates the second point counts as the lower end.
        if (c0 < c1) begin
          lo = c0; hi = c1; zlo = h0; zhi = h1;
        end else begin
          lo = c1; hi = c0; zlo = h1; zhi = h0;
        end
        span = hi - lo;
        rel = probe - lo;
        if (rel < 0) begin
          height = zlo;
        end else if (rel >= span) begin
          height = zhi;
        end else begin
          height = zlo + ((rise * rel) >>> RISE_FRAC);
        end
        // The far end itself still counts as on the segment.
        on = (rel >= 0) && (span >= rel);
      end else begin
        desc = (c1 - c0) < 0;
        rel = probe - c0;
        if (c0 < c1) begin
          lo = c0; span = c1 - c0; zlo = h0; zhi = h1;
        end else begin
          lo = c1; span = c0 - c1; zlo = h1; zhi = h0;
        end
        pos = probe - lo;
        t = (rel * scale) >>> T_SHIFT;
        if (desc) begin
          t = -t;
        end
        slope = s0 + (((s1 - s0) * t) >>> FRAC);
        slope = int'(shortint'(slope));
        if (desc) begin
          slope = -slope;
        end
        if (pos < 0) begin
          height = zlo;
          on = 1'b0;
        end else if (pos >= span) begin
          // Unlike the straight case, the far end is off the segment.
          height = zhi;
          on = 1'b0;
        end else begin
          d1 = hand <<< HSCALE;
          d2 = rise <<< HSCALE;
          q0 = h0 + ((d1 * t) >>> FRAC);
          q1 = lerp10(h0 + d1, h1 + d2, t);
          q2 = h1 + d2 + (((-d2) * t) >>> FRAC);
          m0 = lerp10(q0, q1, t);
          m1 = lerp10(q1, q2, t);
          height = lerp10(m0, m1, t);
          on = 1'b1;
        end
      end
      o.height = height;
      o.on_segment = on;
      o.slope_value = slope[7:0];
      o.slope_on_x = r.along_x ? slope[7:0] : 8'sd0;
      o.slope_on_y = r.along_x ? 8'sd0 : slope[7:0];
      o.axis_is_x = r.along_x;
      o.offset_from_first = offset;
      return o;
    endfunction

    function void note_request(req_t r);
      expected_samples.push_back(predict_sample(r));
      requests++;
      if (r.curved) begin
        curved_requests++;
      end
    endfunction

    function void compare_field(string field, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      responses++;
      if (got.on_segment) begin
        on_segment_hits++;
      end
      if (expected_samples.size() == 0) begin
        $error("response transfer with no request outstanding: height %0d", got.height);
        errors++;
        return;
      end
      want = expected_samples.pop_front();
      compare_field("height", want.height, got.height);
      compare_field("on_segment", want.on_segment, got.on_segment);
      compare_field("slope_on_x", want.slope_on_x, got.slope_on_x);
      compare_field("slope_on_y", want.slope_on_y, got.slope_on_y);
      compare_field("slope_value", want.slope_value, got.slope_value);
      compare_field("axis_is_x", want.axis_is_x, got.axis_is_x);
      compare_field("offset_from_first", want.offset_from_first, got.offset_from_first);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Percentage of cycles in which each side holds back; dropped to zero for
  // one long stretch of the random phase so the pipeline also runs flat out.
  int idle_pct = 36;

  height_scoreboard board = new();

  segment_height_sampler i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiving side: every edge checks a completed response transfer,
  // using the values that were present just before the edge, and then picks
  // the ready level for the next cycle.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      board.check_response(rsp);
    end
    rsp_ready <= ($urandom_range(99) >= idle_pct);
  end

  // Offers one request and returns once it has been transferred. Any idle
  // gap comes first, so valid stays high across back-to-back transfers and
  // is never lowered and raised within the same time step.
  task automatic send_request(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do begin
      @(posedge clk);
    end while (!req_ready);
    board.note_request(r);
  endtask

  function automatic req_t build_segment(int curved, int along_x, int c0, int c1, int h0,
                                         int h1, int probe, int rise, int s0, int s1,
                                         int scale, int hand);
    req_t r;
    r.curved = curved[0];
    r.along_x = along_x[0];
    r.first_coord = 16'(c0);
    r.second_coord = 16'(c1);
    r.first_height = 16'(h0);
    r.second_height = 16'(h1);
    r.probe_pos = probe;
    r.rise = 16'(rise);
    r.slope_start = 8'(s0);
    r.slope_end = 8'(s1);
    r.param_scale = 16'(scale);
    r.start_handle = 16'(hand);
    return r;
  endfunction

  initial begin
    req_t       r;
    bit [191:0] noise;
    int         n, span, lo, probe, first, second, scale;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Straight ascending segment: below the span, at its lower end, inside,
    // exactly at the far end and just past it.
    send_request(build_segment(0, 1, 10, 20, 5, 50, 319, 'h0180, 12, 0, 0, 0));
    send_request(build_segment(0, 1, 10, 20, 5, 50, 320, 'h0180, 12, 0, 0, 0));
    send_request(build_segment(0, 1, 10, 20, 5, 50, 480, 'h0180, 12, 0, 0, 0));
    send_request(build_segment(0, 1, 10, 20, 5, 50, 640, 'h0180, 12, 0, 0, 0));
    send_request(build_segment(0, 1, 10, 20, 5, 50, 641, 'h0180, 12, 0, 0, 0));
    // Straight segment given high end first, on the y axis.
    send_request(build_segment(0, 0, 20, 10, 5, 50, 400, -'h0100, -7, 0, 0, 0));
    // Empty span: at the shared coordinate and just below it.
    send_request(build_segment(0, 1, 7, 7, 3, 9, 224, 'h0100, 4, 0, 0, 0));
    send_request(build_segment(0, 0, 7, 7, 3, 9, 223, 'h0100, 4, 0, 0, 0));
    // Curved ascending segment over 64 units, t reaching 1.0 at the far end.
    send_request(build_segment(1, 1, 0, 64, 100, -100, 1024, 40, -20, 90, 32768, -30));
    send_request(build_segment(1, 1, 0, 64, 100, -100, 2048, 40, -20, 90, 32768, -30));
    send_request(build_segment(1, 0, 0, 64, 100, -100, -1, 40, -20, 90, 32768, -30));
    send_request(build_segment(1, 0, 0, 64, 100, -100, 0, 40, -20, 90, 32768, -30));
    // Descending curve: t and the slope are both negated.
    send_request(build_segment(1, 0, 64, 0, 100, -100, 1024, 40, -20, 90, 32768, -30));
    // Curve with an empty span.
    send_request(build_segment(1, 1, 5, 5, 10, 20, 160, 40, 3, 9, 1000, 8));
    // Interpolated slope far outside a byte, so only its low bits survive.
    send_request(build_segment(1, 1, -1000, 1000, 0, 0, 63999, 0, -128, 127, 65535, 0));
    // Negating a slope of -128 wraps back onto itself within a byte.
    send_request(build_segment(1, 0, 100, 0, 0, 0, 1600, 0, -128, -128, 20000, 0));
    // Field extremes, where the intermediate products wrap.
    send_request(build_segment(0, 1, -32768, 32767, 32767, -32768, 'h7fffffff, 32767, 127,
                               -128, 65535, -32768));
    send_request(build_segment(1, 1, -32768, 32767, 32767, -32768, 32767 * 32 - 1, 32767,
                               127, -128, 65535, -32768));
    send_request(build_segment(1, 0, 32767, -32768, -32768, 32767, 'h80000000, -32768, -128,
                               127, 0, 32767));
    send_request(build_segment(0, 0, 32767, -32768, -32768, 32767, 'h80000000, -32768, -128,
                               127, 0, 32767));
    send_request(build_segment(1, 1, -32768, 32767, -32768, 32767, 0, -32768, 127, -128,
                               65535, 32767));

    // Random phase. Most items are sensible segments with the probe near the
    // span and t scaled to cover it; a quarter are entirely random words.
    for (n = 0; n < 1550; n++) begin
      idle_pct = (n >= 600 && n < 900) ? 0 : 36;
      if ($urandom_range(99) < 25) begin
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        r = noise[$bits(req_t)-1:0];
      end else begin
        span = ($urandom_range(4) == 0) ? $urandom_range(32767) : $urandom_range(200);
        lo = $urandom_range(65535 - span) - 32768;
        if ($urandom_range(1)) begin
          first = lo;
          second = lo + span;
        end else begin
          first = lo + span;
          second = lo;
        end
        case ($urandom_range(7))
          0: probe = lo * 32;
          1: probe = (lo + span) * 32;
          2: probe = (lo + span) * 32 - 1;
          3: probe = lo * 32 - 1;
          default: probe = lo * 32 - span * 8 - 16 + int'($urandom_range(span * 48 + 32));
        endcase
        if (span == 0 || $urandom_range(9) == 0) begin
          scale = $urandom_range(65535);
        end else begin
          scale = ((1 << 21) / span > 65535) ? 65535 : (1 << 21) / span;
        end
        r = build_segment($urandom_range(1), $urandom_range(1), first, second, $urandom,
                          $urandom, probe, $urandom, $urandom, $urandom, scale, $urandom);
      end
      send_request(r);
    end
    req_valid <= 1'b0;
    idle_pct = 36;

    while (board.expected_samples.size() != 0) begin
      @(posedge clk);
    end
    // Give any stray response time to surface before the verdict.
    repeat (2 * STAGES) @(posedge clk);

    $display("Sampled %0d segments (%0d curved) across straight, curved, empty and",
             board.requests, board.curved_requests);
    $display("reversed spans; %0d responses seen, %0d of them on the segment.",
             board.responses, board.on_segment_hits);
    if (board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legitimate run.
  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
